// File: sv/i2c_mbe_pkg.sv
package i2c_mbe_pkg;

    localparam int DELAY_W   = 16;
    localparam int RETRY_W   = 16;
    localparam int BYTE_W    = 8;
    localparam int ACTION_W  = 3;
    localparam int BIT_IDX_W = 4;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 16;
    localparam int ADDR_W    = 3;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd20;
    localparam logic [RETRY_W-1:0] RETRY_RESET = 16'd250;
    localparam logic [BIT_IDX_W-1:0] LAST_BIT  = 4'd7;

    localparam logic [ADDR_W-1:0] ADDR_DELAY = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_RETRY = 3'd4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 3'd0,
        ACT_START = 3'd1,
        ACT_STOP  = 3'd2,
        ACT_WRITE = 3'd3,
        ACT_READ  = 3'd4
    } action_t;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_ST_A    = 5'd1,
        PH_ST_B    = 5'd2,
        PH_ST_C    = 5'd3,
        PH_SP_A    = 5'd4,
        PH_SP_B    = 5'd5,
        PH_SP_C    = 5'd6,
        PH_WR_DATA = 5'd7,
        PH_WR_HIGH = 5'd8,
        PH_WR_LOW  = 5'd9,
        PH_WA_REL  = 5'd10,
        PH_WA_HIGH = 5'd11,
        PH_WA_POLL = 5'd12,
        PH_RD_LOW  = 5'd13,
        PH_RD_HIGH = 5'd14,
        PH_RD_END  = 5'd15,
        PH_AK_SET  = 5'd16,
        PH_AK_HIGH = 5'd17,
        PH_AK_LOW  = 5'd18
    } phase_t;

    typedef struct packed {
        logic start_cmd;
        logic enter_en;
        logic fin;
        logic ack_low;
        logic poll_to;
        logic poll_dec;
        logic delay_dec;
        logic inc_bit;
        logic load_retry;
    } step_ctl_t;

endpackage

// File: sv/i2c_master_bit_engine.sv
// channel   | direction | handshake        | payload
// s_ (tick) | in        | s_tvalid/tready  | s_tdata: action, tx_byte, ack_enable, sda_in
// m_ (pins) | out       | m_tvalid/tready  | m_tdata: pins, busy, done, status, rx_byte
// apb cfg   | in        | psel/penable     | 0x0 delay_ticks, 0x4 ack_retry_limit
//
// one item per cycle while the result is not stalled: each tick updates the bit state and lands in the output register
// the result of an accepted tick is registered and shown in the cycle after it is accepted
// aresetn is synchronous and active low; scl and sda driven high, engine idle
// a stalled result holds m_tdata and the engine stops; a new tick enters as the old one leaves
module i2c_master_bit_engine
    import i2c_mbe_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // action[2:0], tx_byte[10:3], ack_enable[11], sda_in[12], zero pad
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // scl_level[0], sda_level[1], sda_drive[2], busy_res[3], done_res[4],
    // status[5], rx_byte[13:6], zero pad
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [DELAY_W-1:0]   delay_ticks_reg;
    logic [RETRY_W-1:0]   retry_limit_reg;

    phase_t               phase_reg, phase_next;
    logic [ACTION_W-1:0]  command_reg, command_next;
    logic [BIT_IDX_W-1:0] bit_index_reg, bit_index_next;
    logic [BYTE_W-1:0]    shift_reg, shift_next;
    logic [DELAY_W-1:0]   delay_count_reg, delay_count_next;
    logic [RETRY_W-1:0]   retry_count_reg, retry_count_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 sda_oe_reg, sda_oe_next;
    logic                 ack_flag_reg, ack_flag_next;
    logic [BYTE_W-1:0]    rx_reg, rx_next;
    logic                 status_next;

    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic [ACTION_W-1:0]  s_action;
    logic [BYTE_W-1:0]    s_tx_byte;
    logic                 s_ack_enable;
    logic                 s_sda_in;
    logic                 accept;
    logic [DELAY_W-1:0]   pause_load;
    step_ctl_t            ctl;

    assign s_action     = s_tdata[2:0];
    assign s_tx_byte    = s_tdata[10:3];
    assign s_ack_enable = s_tdata[11];
    assign s_sda_in     = s_tdata[12];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign pause_load = (delay_ticks_reg == '0) ? '0 : delay_ticks_reg - 1'b1;

    // config port
    assign pready = 1'b1;

    always_comb begin
        case (paddr)
            ADDR_DELAY: prdata = {16'd0, delay_ticks_reg};
            ADDR_RETRY: prdata = {16'd0, retry_limit_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_ticks_reg <= DELAY_RESET;
            retry_limit_reg <= RETRY_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_DELAY) begin
                delay_ticks_reg <= pwdata[DELAY_W-1:0];
            end else if (paddr == ADDR_RETRY) begin
                retry_limit_reg <= pwdata[RETRY_W-1:0];
            end
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        ctl        = '0;
        case (phase_reg)
            PH_IDLE: begin
                ctl.start_cmd = 1'b1;
                ctl.enter_en  = 1'b1;
                case (s_action)
                    ACT_START: phase_next = PH_ST_A;
                    ACT_STOP:  phase_next = PH_SP_A;
                    ACT_WRITE: phase_next = PH_WR_DATA;
                    ACT_READ:  phase_next = PH_RD_LOW;
                    default: begin
                        ctl.start_cmd = 1'b0;
                        ctl.enter_en  = 1'b0;
                    end
                endcase
            end
            PH_WA_POLL: begin
                if (!s_sda_in) begin
                    phase_next  = PH_IDLE;
                    ctl.fin     = 1'b1;
                    ctl.ack_low = 1'b1;
                end else if (retry_count_reg == '0) begin
                    phase_next   = PH_SP_A;
                    ctl.poll_to  = 1'b1;
                    ctl.enter_en = 1'b1;
                end else begin
                    ctl.poll_dec = 1'b1;
                end
            end
            default: begin
                if (delay_count_reg != '0) begin
                    ctl.delay_dec = 1'b1;
                end else begin
                    ctl.enter_en = 1'b1;
                    case (phase_reg)
                        PH_ST_A:    phase_next = PH_ST_B;
                        PH_ST_B:    phase_next = PH_ST_C;
                        PH_SP_A:    phase_next = PH_SP_B;
                        PH_SP_B:    phase_next = PH_SP_C;
                        PH_WR_DATA: phase_next = PH_WR_HIGH;
                        PH_WR_HIGH: phase_next = PH_WR_LOW;
                        PH_WR_LOW: begin
                            if (bit_index_reg < LAST_BIT) begin
                                ctl.inc_bit = 1'b1;
                                phase_next  = PH_WR_DATA;
                            end else begin
                                phase_next = PH_WA_REL;
                            end
                        end
                        PH_WA_REL:  phase_next = PH_WA_HIGH;
                        PH_WA_HIGH: begin
                            phase_next     = PH_WA_POLL;
                            ctl.enter_en   = 1'b0;
                            ctl.load_retry = 1'b1;
                        end
                        PH_RD_LOW:  phase_next = PH_RD_HIGH;
                        PH_RD_HIGH: begin
                            if (bit_index_reg < LAST_BIT) begin
                                ctl.inc_bit = 1'b1;
                                phase_next  = PH_RD_LOW;
                            end else begin
                                phase_next = PH_RD_END;
                            end
                        end
                        PH_RD_END:  phase_next = PH_AK_SET;
                        PH_AK_SET:  phase_next = PH_AK_HIGH;
                        PH_AK_HIGH: phase_next = PH_AK_LOW;
                        default: begin
                            phase_next   = PH_IDLE;
                            ctl.enter_en = 1'b0;
                            ctl.fin      = 1'b1;
                        end
                    endcase
                end
            end
        endcase
    end

    // datapath and pin levels
    always_comb begin
        command_next     = command_reg;
        bit_index_next   = bit_index_reg;
        shift_next       = shift_reg;
        delay_count_next = delay_count_reg;
        retry_count_next = retry_count_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        sda_oe_next      = sda_oe_reg;
        ack_flag_next    = ack_flag_reg;
        rx_next          = rx_reg;
        status_next      = 1'b0;

        if (ctl.start_cmd) begin
            command_next   = s_action;
            bit_index_next = '0;
            ack_flag_next  = 1'b0;
            shift_next     = '0;
            if (s_action == ACT_WRITE) begin
                shift_next = s_tx_byte;
            end
            if (s_action == ACT_READ) begin
                ack_flag_next = s_ack_enable;
            end
        end
        if (ctl.ack_low) begin
            scl_next = 1'b0;
        end
        if (ctl.poll_to) begin
            ack_flag_next = 1'b1;
        end
        if (ctl.poll_dec) begin
            retry_count_next = retry_count_reg - 1'b1;
        end
        if (ctl.delay_dec) begin
            delay_count_next = delay_count_reg - 1'b1;
        end
        if (ctl.inc_bit) begin
            bit_index_next = bit_index_reg + 1'b1;
        end
        if (ctl.load_retry) begin
            retry_count_next = retry_limit_reg;
        end
        if (ctl.fin && !ctl.ack_low) begin
            if (command_reg == ACT_READ) begin
                rx_next = shift_reg;
            end
            status_next = (command_reg == ACT_WRITE) && ack_flag_reg;
        end

        if (ctl.enter_en) begin
            delay_count_next = pause_load;
            case (phase_next)
                PH_ST_A: begin
                    sda_oe_next = 1'b1;
                    scl_next    = 1'b1;
                    sda_next    = 1'b1;
                end
                PH_ST_B: sda_next = 1'b0;
                PH_ST_C: scl_next = 1'b0;
                PH_SP_A: begin
                    sda_oe_next = 1'b1;
                    scl_next    = 1'b0;
                    sda_next    = 1'b0;
                end
                PH_SP_B: scl_next = 1'b1;
                PH_SP_C: sda_next = 1'b1;
                PH_WR_DATA: begin
                    sda_oe_next = 1'b1;
                    scl_next    = 1'b0;
                    sda_next    = shift_next[BYTE_W-1];
                    shift_next  = {shift_next[BYTE_W-2:0], 1'b0};
                end
                PH_WR_HIGH: scl_next = 1'b1;
                PH_WR_LOW:  scl_next = 1'b0;
                PH_WA_REL: begin
                    sda_oe_next = 1'b0;
                    sda_next    = 1'b1;
                end
                PH_WA_HIGH: scl_next = 1'b1;
                PH_RD_LOW: begin
                    sda_oe_next = 1'b0;
                    sda_next    = 1'b1;
                    scl_next    = 1'b0;
                end
                PH_RD_HIGH: begin
                    scl_next   = 1'b1;
                    shift_next = {shift_next[BYTE_W-2:0], s_sda_in};
                end
                PH_RD_END: scl_next = 1'b0;
                PH_AK_SET: begin
                    scl_next    = 1'b0;
                    sda_oe_next = 1'b1;
                    sda_next    = !ack_flag_next;
                end
                PH_AK_HIGH: scl_next = 1'b1;
                PH_AK_LOW:  scl_next = 1'b0;
                default: ;
            endcase
        end

        m_tdata_next = {2'b00, rx_next, status_next, ctl.fin, phase_next != PH_IDLE,
                        sda_oe_next, sda_next, scl_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            command_reg     <= '0;
            bit_index_reg   <= '0;
            shift_reg       <= '0;
            delay_count_reg <= '0;
            retry_count_reg <= '0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            sda_oe_reg      <= 1'b1;
            ack_flag_reg    <= 1'b0;
            rx_reg          <= '0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            command_reg     <= command_next;
            bit_index_reg   <= bit_index_next;
            shift_reg       <= shift_next;
            delay_count_reg <= delay_count_next;
            retry_count_reg <= retry_count_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
            sda_oe_reg      <= sda_oe_next;
            ack_flag_reg    <= ack_flag_next;
            rx_reg          <= rx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[4]) |-> !m_tdata[3])
        else $error("done reported while busy");

    a_status_with_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[5]) |-> m_tdata[4])
        else $error("status set without done");

    a_poll_released: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_WA_POLL) |-> (!sda_oe_reg && scl_reg))
        else $error("ack poll with sda driven or scl low");

    a_bit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_index_reg <= LAST_BIT)
        else $error("bit index out of range");

    a_busy_tracks_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_tdata[3] == (phase_reg != PH_IDLE)))
        else $error("busy flag disagrees with phase");

endmodule
